[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg - shared types and constants for the bounded deque
// Capacity, field widths, operation and status codes, cell control types.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

   // Storage depth and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int COUNT_W  = 5;
   localparam int WORD_W   = 32;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   // Operation codes carried on the request channel
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4,
      OP_SEARCH     = 3'd5
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // What every cell does with its word
   typedef enum logic [1:0] {
      CELL_HOLD        = 2'd0,
      CELL_SHIFT_BACK  = 2'd1,  // take the word of the cell nearer the front
      CELL_SHIFT_FRONT = 2'd2,  // take the word of the cell nearer the back
      CELL_LOAD_BACK   = 2'd3   // the cell at index count loads the new word
   } cell_cmd_type;

   // Broadcast control from the top level to the row of cells
   typedef struct packed {
      cell_cmd_type              cmd;
      logic signed [WORD_W-1:0]  value;
      logic [COUNT_W-1:0]        count;
      logic [COUNT_W-1:0]        position;
   } cell_ctl_type;

   // Per-cell status back to the top level
   typedef struct packed {
      logic signed [WORD_W-1:0]  data;
      logic                      match;     // holds a live word equal to value
      logic                      read_hit;  // is the live word at position
      logic                      back_hit;  // is the live word at the back
   } cell_out_type;

endpackage

`default_nettype wire

[rtl/bdq_if.sv]
// ----------------------------------------------------------------------------
// bdq_if - request and response channel interfaces
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if
   import bdq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [2:0]                op;
   logic signed [WORD_W-1:0]  value;
   logic [COUNT_W-1:0]        position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface bdq_rsp_if
   import bdq_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [WORD_W-1:0]  read_data;
   logic                      found;
   logic [COUNT_W-1:0]        count;
   logic signed [WORD_W-1:0]  front_word;
   logic signed [WORD_W-1:0]  back_word;
   logic [1:0]                status;

   modport source (output valid, output read_data, output found, output count,
                   output front_word, output back_word, output status, input ready);
   modport sink   (input valid, input read_data, input found, input count,
                   input front_word, input back_word, input status, output ready);
endinterface

`default_nettype wire

[rtl/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell - one storage cell of the deque row
// Holds one word, shifts with its neighbors, and flags search, read and back hits.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell
   import bdq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic [IDX_W-1:0]          idx,
   input  wire cell_ctl_type              ctl,
   input  wire logic signed [WORD_W-1:0]  front_data,  // neighbor nearer the front
   input  wire logic signed [WORD_W-1:0]  back_data,   // neighbor nearer the back
   output      cell_out_type              cell_out
);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;
   logic [COUNT_W-1:0]       my_pos;
   logic                     live;

   assign my_pos = COUNT_W'(idx);
   assign live   = (my_pos < ctl.count);

   // Next word for this cell
   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         CELL_SHIFT_BACK:  data_in = front_data;
         CELL_SHIFT_FRONT: data_in = back_data;
         CELL_LOAD_BACK: begin
            if (my_pos == ctl.count) data_in = ctl.value;
         end
         default:          data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Hit flags against the current contents
   assign cell_out.data     = data_ff;
   assign cell_out.match    = live && (data_ff == ctl.value);
   assign cell_out.read_hit = live && (my_pos == ctl.position);
   assign cell_out.back_hit = (ctl.count == my_pos + COUNT_W'(1));

endmodule

`default_nettype wire

[rtl/bounded_deque_with_search.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_search - bounded deque of signed words with read and search
// A row of shifting cells keeps the front word in cell 0; every request gives
// one response with the read data, search flag, count, front and back words.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   req_chan  in         op, value, position
//   rsp_chan  out        read_data, found, count, front_word, back_word, status
//
// One request per cycle: a request updates the cell row at its accepting edge
// and its response is valid in the next cycle.
// Search compares all cells at once; indexed read selects by cell position.
// A new request is taken when no response is pending or the pending response is taken in the same cycle;
// while a response stalls, requests wait. Synchronous reset empties the deque.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search
   import bdq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   bdq_req_if.sink    req_chan,
   bdq_rsp_if.source  rsp_chan
);

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0]  read_data_ff, read_data_in;
   logic                      found_ff, found_in;
   status_type                status_ff, status_in;

   cell_ctl_type              ctl;
   cell_out_type              cell_out [CAPACITY];
   logic                      req_accept;
   logic                      full, empty;
   op_type                    op;

   logic signed [WORD_W-1:0]  read_word;
   logic signed [WORD_W-1:0]  back_word;
   logic                      any_match;

   assign op         = op_type'(req_chan.op);
   assign full       = (count_ff == CAP_COUNT);
   assign empty      = (count_ff == '0);
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [WORD_W-1:0] front_nb;
      logic signed [WORD_W-1:0] back_nb;
      if (i == 0) begin : g_first
         assign front_nb = req_chan.value;
      end else begin : g_mid
         assign front_nb = cell_out[i-1].data;
      end
      if (i == CAPACITY-1) begin : g_last
         assign back_nb = '0;
      end else begin : g_inner
         assign back_nb = cell_out[i+1].data;
      end
      bdq_cell u_cell (
         .clock      (clock),
         .idx        (IDX_W'(i)),
         .ctl        (ctl),
         .front_data (front_nb),
         .back_data  (back_nb),
         .cell_out   (cell_out[i])
      );
   end

   // Gather hit flags from the row
   always_comb begin
      read_word = '0;
      back_word = '0;
      any_match = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_out[i].read_hit) read_word = read_word | cell_out[i].data;
         if (cell_out[i].back_hit) back_word = back_word | cell_out[i].data;
         any_match = any_match | cell_out[i].match;
      end
   end

   // Decode the request into a cell command, new count and result
   always_comb begin
      ctl.cmd      = CELL_HOLD;
      ctl.value    = req_chan.value;
      ctl.count    = count_ff;
      ctl.position = req_chan.position;
      count_in     = count_ff;
      read_data_in = read_data_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         read_data_in = '0;
         found_in     = 1'b0;
         status_in    = ST_OK;
         case (op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.cmd  = CELL_SHIFT_BACK;
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.cmd  = CELL_LOAD_BACK;
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctl.cmd  = CELL_SHIFT_FRONT;
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            OP_READ: begin
               if (req_chan.position >= count_ff) begin
                  status_in = ST_RANGE;
               end else begin
                  read_data_in = read_word;
               end
            end
            OP_SEARCH: begin
               found_in = any_match;
            end
            default: begin
               // unused codes leave the deque alone
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
   end

   // Response: front and back come straight from the row
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_data  = read_data_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.count      = count_ff;
   assign rsp_chan.front_word = empty ? '0 : cell_out[0].data;
   assign rsp_chan.back_word  = back_word;
   assign rsp_chan.status     = status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("deque count above capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !full
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("push did not grow the deque");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      req_accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && full
      |=> status_ff == ST_FULL && count_ff == CAP_COUNT)
      else $error("dropped push not flagged");

   a_push_front_word: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == OP_PUSH_FRONT && !full
      |=> rsp_chan.front_word == $past(req_chan.value))
      else $error("pushed word not at the front");

endmodule

`default_nettype wire

[sim/deque_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker - response predictor and scoreboard for the bounded deque
// Watches both channels, models the deque for every accepted request and
// compares each accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module deque_checker
   import bdq_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   bdq_req_if    req_mon,
   bdq_rsp_if    rsp_mon,
   output int    error_count,
   output int    pending
);

   // One predicted response
   typedef struct packed {
      logic signed [WORD_W-1:0]  read_data;
      logic                      found;
      logic [COUNT_W-1:0]        count;
      logic signed [WORD_W-1:0]  front_word;
      logic signed [WORD_W-1:0]  back_word;
      logic [1:0]                status;
   } deque_result_type;

   // Shadow copy of the deque storage
   logic signed [WORD_W-1:0]  word_store [CAPACITY];
   logic [IDX_W-1:0]          head_slot;
   logic [COUNT_W-1:0]        word_count;

   deque_result_type          expected_q [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic signed [WORD_W-1:0] want,
                              input logic signed [WORD_W-1:0] got);
      if (want !== got)
         report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // Apply one operation to the shadow deque and work out its response
   task automatic predict_transaction(input logic [2:0] op,
                                      input logic signed [WORD_W-1:0] word,
                                      input logic [COUNT_W-1:0] pos,
                                      output deque_result_type res);
      logic [IDX_W-1:0] idx;
      int i;
      res = '0;
      res.status = ST_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (word_count >= CAP_COUNT) begin
               res.status = ST_FULL;
            end else begin
               head_slot = head_slot - 1'b1;
               word_store[head_slot] = word;
               word_count = word_count + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (word_count >= CAP_COUNT) begin
               res.status = ST_FULL;
            end else begin
               idx = head_slot + word_count[IDX_W-1:0];
               word_store[idx] = word;
               word_count = word_count + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (word_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               head_slot = head_slot + 1'b1;
               word_count = word_count - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (word_count == 0) res.status = ST_EMPTY;
            else word_count = word_count - 1'b1;
         end
         OP_READ: begin
            if (pos >= word_count) begin
               res.status = ST_RANGE;
            end else begin
               idx = head_slot + pos[IDX_W-1:0];
               res.read_data = word_store[idx];
            end
         end
         OP_SEARCH: begin
            for (i = 0; i < word_count; i++) begin
               idx = head_slot + i[IDX_W-1:0];
               if (word_store[idx] == word) res.found = 1'b1;
            end
         end
         default: ;  // spare codes leave the deque alone
      endcase
      res.count = word_count;
      if (word_count != 0) begin
         res.front_word = word_store[head_slot];
         idx = head_slot + word_count[IDX_W-1:0] - 1'b1;
         res.back_word = word_store[idx];
      end
   endtask

   // Predict on request transactions, compare on response transactions
   always @(posedge clock) begin : scoreboard
      deque_result_type want;
      if (reset) begin
         head_slot   = '0;
         word_count  = '0;
         for (int k = 0; k < CAPACITY; k++) word_store[k] = '0;
         expected_q.delete();
         error_count = 0;
         pending    <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_transaction(req_mon.op, req_mon.value, req_mon.position, want);
            expected_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("response transaction with nothing outstanding");
            end else begin
               want = expected_q.pop_front();
               check_field("read_data", want.read_data, rsp_mon.read_data);
               check_field("found", want.found, rsp_mon.found);
               check_field("count", want.count, rsp_mon.count);
               check_field("front_word", want.front_word, rsp_mon.front_word);
               check_field("back_word", want.back_word, rsp_mon.back_word);
               check_field("status", want.status, rsp_mon.status);
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - top level testbench for the bounded deque with search
// Drives directed corner cases and then random operation mixes that fill and
// drain the deque, with random idle gaps and response back-pressure.
// ----------------------------------------------------------------------------

module tb
   import bdq_pkg::*;
();

   localparam logic [2:0] OP_SPARE_LO  = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam int         RANDOM_ITEMS = 1950;
   localparam int         CYCLE_LIMIT  = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   fail_count;
   int   outstanding;
   int   cycle_count = 0;
   bit   steady = 1'b0;      // no idling on either side while set
   int   level = 0;          // rough fill level used to steer stimulus
   logic signed [WORD_W-1:0] recent_words [$];

   bdq_req_if req_bus ();
   bdq_rsp_if rsp_bus ();

   bounded_deque_with_search i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   deque_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .error_count (fail_count),
      .pending     (outstanding)
   );

   always #2 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2, 3:    return $urandom_range(0, 7);
         4:       return -1;
         default: return $urandom();
      endcase
   endfunction

   // One request transaction, with an optional idle gap in front
   task automatic send_item(input logic [2:0] op, input logic signed [WORD_W-1:0] word,
                            input logic [COUNT_W-1:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.value    <= word;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (level < CAPACITY) level++;
            recent_words.push_back(word);
            if (recent_words.size() > 24) void'(recent_words.pop_front());
         end
         OP_POP_FRONT, OP_POP_BACK: if (level > 0) level--;
         default: ;
      endcase
   endtask

   // Hold off the sender until every response has come back
   task automatic drain_wait();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Response side back-pressure
   initial begin : rsp_stall
      int stall;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      int mode, push_pct, pop_pct, r, n;
      logic [2:0]               op;
      logic signed [WORD_W-1:0] word;
      logic [COUNT_W-1:0]       pos;

      req_bus.valid    <= 1'b0;
      req_bus.op       <= OP_PUSH_FRONT;
      req_bus.value    <= '0;
      req_bus.position <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty deque corners and spare codes
      send_item(OP_POP_FRONT, 0, '0);
      send_item(OP_POP_BACK, 0, '0);
      send_item(OP_READ, 0, '0);
      send_item(OP_SEARCH, 0, '0);
      send_item(OP_SPARE_LO, 32'sh7FFF_FFFF, 5'd31);
      send_item(OP_SPARE_HI, 32'sh8000_0000, 5'd16);

      // Fill from both ends, extremes first, then push while full
      send_item(OP_PUSH_BACK, 32'sh7FFF_FFFF, '0);
      send_item(OP_PUSH_FRONT, 32'sh8000_0000, '0);
      send_item(OP_PUSH_BACK, 0, '0);
      send_item(OP_PUSH_FRONT, -1, '0);
      for (n = 4; n < CAPACITY; n++)
         send_item(n[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom(), '0);
      send_item(OP_PUSH_FRONT, 32'sh1234_5678, '0);
      send_item(OP_PUSH_BACK, 32'sh1234_5678, '0);

      // Reads at the last position and at count
      send_item(OP_READ, 0, 5'd15);
      send_item(OP_READ, 0, 5'd16);
      send_item(OP_SEARCH, 32'sh8000_0000, '0);
      drain_wait();

      // Random mixes biased toward filling, draining or neither
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            mode   = $urandom_range(0, 2);
            steady = ($urandom_range(0, 3) == 0);
            case (mode)
               0:       begin push_pct = 60; pop_pct = 12; end
               1:       begin push_pct = 12; pop_pct = 60; end
               default: begin push_pct = 30; pop_pct = 30; end
            endcase
         end
         if (n % 500 == 499) drain_wait();

         r    = $urandom_range(0, 99);
         word = pick_word();
         pos  = COUNT_W'($urandom_range(0, 31));
         if (r < 2) begin
            op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
         end else if (r < 2 + push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         end else if (r < 2 + push_pct + pop_pct) begin
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end else if (r < 2 + push_pct + pop_pct + (98 - push_pct - pop_pct) / 2) begin
            op = OP_READ;
            if ($urandom_range(0, 9) < 7) pos = COUNT_W'($urandom_range(0, level));
         end else begin
            op = OP_SEARCH;
            if (recent_words.size() != 0 && $urandom_range(0, 9) < 6)
               word = recent_words[$urandom_range(0, recent_words.size() - 1)];
         end
         send_item(op, word, pos);
      end

      // Let the last responses come back
      steady = 1'b0;
      drain_wait();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
